### src/baro_sensor_temp_sequencer_defines.svh
`ifndef BARO_SENSOR_TEMP_SEQUENCER_DEFINES_SVH
`define BARO_SENSOR_TEMP_SEQUENCER_DEFINES_SVH

// same-cycle implication, reset masks the check
`define BST_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sequencer check failed");

// next-cycle implication, reset masks the check
`define BST_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sequencer check failed");

`endif

### src/bst_pkg.sv
`default_nettype none
package bst_pkg;

  localparam int CMD_W = 2;
  localparam int KIND_W = 3;
  localparam int LEN_W = 5;
  localparam int POS_W = 5;
  localparam int TEMP_W = 24;
  localparam int START_W = 24;
  localparam int CONV_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;
  localparam int CAL_W = 16;

  localparam int CAL_BYTES = 22;

  // event codes
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WDONE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_BYTE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_WRITE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_READ = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TEMP = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ID_ERR = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DIV_ERR = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_WAIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONV_WAIT = 2'd1;

  localparam logic [START_W-1:0] START_WAIT_RST = 24'd2000;
  localparam logic [CONV_W-1:0] CONV_WAIT_RST = 16'd5;

  // bus constants
  localparam logic [7:0] ADDR_WRITE = 8'hee;
  localparam logic [7:0] ADDR_READ = 8'hef;
  localparam logic [7:0] REG_ID = 8'hd0;
  localparam logic [7:0] REG_CAL = 8'haa;
  localparam logic [7:0] REG_CTRL = 8'hf4;
  localparam logic [7:0] REG_RESULT = 8'hf6;
  localparam logic [7:0] CONV_TEMP = 8'h2e;
  localparam logic [7:0] ID_VALUE = 8'h55;

  // calibration word positions (byte pairs)
  localparam logic [POS_W-1:0] POS_AC5 = 5'd8;
  localparam logic [POS_W-1:0] POS_AC6 = 5'd10;
  localparam logic [POS_W-1:0] POS_MC = 5'd18;
  localparam logic [POS_W-1:0] POS_MD = 5'd20;

  typedef struct packed {
    logic store_raw;
    logic store_cal;
    logic [POS_W-1:0] pos;
    logic start;
  } bst_cmd_t;

  typedef struct packed {
    logic done;
    logic div_zero;
    logic signed [TEMP_W-1:0] temp;
    logic [7:0] raw_high;
  } bst_stat_t;

endpackage
`default_nettype wire

### src/bst_in_if.sv
`default_nettype none
interface bst_in_if import bst_pkg::*; ();
  logic valid;
  logic ready;
  logic [CMD_W-1:0] cmd;
  logic [7:0] rx_byte;
  logic rx_last;

  modport source (output valid, cmd, rx_byte, rx_last, input ready);
  modport sink (input valid, cmd, rx_byte, rx_last, output ready);
endinterface
`default_nettype wire

### src/bst_out_if.sv
`default_nettype none
interface bst_out_if import bst_pkg::*; ();
  logic valid;
  logic ready;
  logic [KIND_W-1:0] kind;
  logic [7:0] bus_addr;
  logic [LEN_W-1:0] xfer_length;
  logic [7:0] write_first;
  logic [7:0] write_second;
  logic signed [TEMP_W-1:0] temp_tenths;
  logic [7:0] sample_index;

  modport source (output valid, kind, bus_addr, xfer_length, write_first, write_second,
                  temp_tenths, sample_index, input ready);
  modport sink (input valid, kind, bus_addr, xfer_length, write_first, write_second,
                temp_tenths, sample_index, output ready);
endinterface
`default_nettype wire

### src/bst_cfg_if.sv
`default_nettype none
interface bst_cfg_if import bst_pkg::*; ();
  logic valid;
  logic ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### src/baro_sensor_temp_sequencer.sv
// barometric sensor temperature sequencer
// evt: one event item per handshake (tick, bus write done, received byte
//   with a last flag); the block answers by issuing bus write and read
//   requests on res, and finally a compensated temperature in tenths
// res: one result item per handshake, held in an output register; every
//   field without meaning for the item's kind is zero
// cfg: register writes (0 start wait ticks, 1 conversion wait ticks),
//   always ready; user writes only while the block is quiet, not enforced
// an event that causes a request shows it on res in the next cycle;
//   ordinary events are taken one per cycle while the output is free
// the last raw byte starts the compensation: one multiply, then a
//   restoring divider giving one quotient bit per cycle, then the
//   temperature item; no events are taken meanwhile
// reset (synchronous, rst high) returns to idle with the tick count,
//   bus state and sample counter cleared and both registers at defaults
// if the receiver stalls, the result stays put and evt.ready drops until
//   the output register is free; an id mismatch halts until reset
`default_nettype none
module baro_sensor_temp_sequencer import bst_pkg::*; (
  input logic clk,
  input logic rst,
  bst_in_if.sink evt,
  bst_out_if.source res,
  bst_cfg_if.sink cfg
);

  bst_cmd_t dcmd;
  bst_stat_t stat;

  // sequencing, bus requests, timing and output register
  bst_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .evt_valid(evt.valid),
    .evt_ready(evt.ready),
    .evt_cmd(evt.cmd),
    .evt_rx_byte(evt.rx_byte),
    .evt_rx_last(evt.rx_last),
    .cfg_valid(cfg.valid),
    .cfg_ready(cfg.ready),
    .cfg_index(cfg.index),
    .cfg_data(cfg.data),
    .res_valid(res.valid),
    .res_ready(res.ready),
    .res_kind(res.kind),
    .res_bus_addr(res.bus_addr),
    .res_xfer_length(res.xfer_length),
    .res_write_first(res.write_first),
    .res_write_second(res.write_second),
    .res_temp_tenths(res.temp_tenths),
    .res_sample_index(res.sample_index),
    .stat(stat),
    .dcmd(dcmd)
  );

  // calibration store and the compensation arithmetic
  bst_dp u_dp (
    .clk(clk),
    .rst(rst),
    .rx_byte(evt.rx_byte),
    .dcmd(dcmd),
    .stat(stat)
  );

endmodule
`default_nettype wire

### src/bst_ctrl.sv
`default_nettype none
module bst_ctrl import bst_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic evt_valid,
  output logic evt_ready,
  input  logic [CMD_W-1:0] evt_cmd,
  input  logic [7:0] evt_rx_byte,
  input  logic evt_rx_last,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic res_valid,
  input  logic res_ready,
  output logic [KIND_W-1:0] res_kind,
  output logic [7:0] res_bus_addr,
  output logic [LEN_W-1:0] res_xfer_length,
  output logic [7:0] res_write_first,
  output logic [7:0] res_write_second,
  output logic signed [TEMP_W-1:0] res_temp_tenths,
  output logic [7:0] res_sample_index,
  input  bst_stat_t stat,
  output bst_cmd_t dcmd
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_ASK_ID, PH_RCV_ID, PH_ASK_CAL, PH_RCV_CAL,
    PH_ASK_TEMP, PH_ASK_TEMP2, PH_RCV_TEMP, PH_CALC, PH_HALT
  } phase_t;

  localparam logic [START_W-1:0] ELAPSED_MAX = {START_W{1'b1}};
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  phase_t phase, phase_next;
  logic [START_W-1:0] elapsed, elapsed_next;
  logic bus_busy, busy_next;
  logic [POS_W-1:0] byte_pos, pos_next;
  logic [7:0] result_count, count_next;
  logic [START_W-1:0] start_wait;
  logic [CONV_W-1:0] conv_wait;

  logic out_free, evt_fire, load;
  logic wait_write, wait_read;
  logic [7:0] id_byte;
  logic [KIND_W-1:0] o_kind;
  logic [7:0] o_addr, o_w1, o_w2, o_idx;
  logic [LEN_W-1:0] o_len;
  logic signed [TEMP_W-1:0] o_temp;

  assign out_free = !res_valid || res_ready;
  assign evt_ready = (phase != PH_CALC) && out_free;
  assign evt_fire = evt_valid && evt_ready;
  assign cfg_ready = 1'b1;

  assign wait_write = (phase == PH_ASK_ID) || (phase == PH_ASK_CAL) ||
                      (phase == PH_ASK_TEMP) || (phase == PH_ASK_TEMP2);
  assign wait_read = (phase == PH_RCV_ID) || (phase == PH_RCV_CAL) || (phase == PH_RCV_TEMP);

  always_comb begin
    phase_next = phase;
    elapsed_next = elapsed;
    busy_next = bus_busy;
    pos_next = byte_pos;
    count_next = result_count;
    load = 1'b0;
    o_kind = KIND_WRITE;
    o_addr = 8'd0;
    o_len = '0;
    o_w1 = 8'd0;
    o_w2 = 8'd0;
    o_temp = '0;
    o_idx = 8'd0;
    dcmd = '0;
    dcmd.pos = byte_pos;
    id_byte = stat.raw_high;

    if (evt_fire && evt_cmd != CMD_NONE && phase != PH_HALT) begin
      case (evt_cmd)
        CMD_TICK: begin
          if (elapsed != ELAPSED_MAX) elapsed_next = elapsed + 1'b1;
        end
        CMD_WDONE: begin
          if (wait_write) busy_next = 1'b0;
        end
        default: begin
          if (wait_read && bus_busy) begin
            dcmd.store_raw = (phase != PH_RCV_CAL);
            dcmd.store_cal = (phase == PH_RCV_CAL);
            if (byte_pos != POS_MAX) pos_next = byte_pos + 1'b1;
            if (evt_rx_last) busy_next = 1'b0;
          end
        end
      endcase
      if (dcmd.store_raw && byte_pos == '0) id_byte = evt_rx_byte;

      if (!busy_next) begin
        case (phase)
          PH_IDLE: begin
            if (elapsed_next > start_wait) begin
              load = 1'b1; o_addr = ADDR_WRITE; o_len = LEN_W'(1); o_w1 = REG_ID;
              busy_next = 1'b1; phase_next = PH_ASK_ID;
            end
          end
          PH_ASK_ID: begin
            load = 1'b1; o_kind = KIND_READ; o_addr = ADDR_READ; o_len = LEN_W'(1);
            busy_next = 1'b1; pos_next = '0; phase_next = PH_RCV_ID;
          end
          PH_RCV_ID: begin
            load = 1'b1;
            if (id_byte != ID_VALUE) begin
              o_kind = KIND_ID_ERR;
              phase_next = PH_HALT;
            end else begin
              o_addr = ADDR_WRITE; o_len = LEN_W'(1); o_w1 = REG_CAL;
              busy_next = 1'b1; phase_next = PH_ASK_CAL;
            end
          end
          PH_ASK_CAL: begin
            load = 1'b1; o_kind = KIND_READ; o_addr = ADDR_READ; o_len = LEN_W'(CAL_BYTES);
            busy_next = 1'b1; pos_next = '0; phase_next = PH_RCV_CAL;
          end
          PH_RCV_CAL: begin
            elapsed_next = '0;
            load = 1'b1; o_addr = ADDR_WRITE; o_len = LEN_W'(2); o_w1 = REG_CTRL;
            o_w2 = CONV_TEMP; busy_next = 1'b1; phase_next = PH_ASK_TEMP;
          end
          PH_ASK_TEMP: begin
            if (elapsed_next > {{(START_W-CONV_W){1'b0}}, conv_wait}) begin
              load = 1'b1; o_addr = ADDR_WRITE; o_len = LEN_W'(1); o_w1 = REG_RESULT;
              busy_next = 1'b1; phase_next = PH_ASK_TEMP2;
            end
          end
          PH_ASK_TEMP2: begin
            load = 1'b1; o_kind = KIND_READ; o_addr = ADDR_READ; o_len = LEN_W'(2);
            busy_next = 1'b1; pos_next = '0; phase_next = PH_RCV_TEMP;
          end
          PH_RCV_TEMP: begin
            dcmd.start = 1'b1;
            elapsed_next = '0;
            phase_next = PH_CALC;
          end
          default: ;
        endcase
      end
    end else if (phase == PH_CALC && stat.done && out_free) begin
      load = 1'b1;
      phase_next = PH_IDLE;
      if (stat.div_zero) begin
        o_kind = KIND_DIV_ERR;
      end else begin
        o_kind = KIND_TEMP;
        o_temp = stat.temp;
        o_idx = result_count;
        count_next = result_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      elapsed <= '0;
      bus_busy <= 1'b0;
      byte_pos <= '0;
      result_count <= 8'd0;
      start_wait <= START_WAIT_RST;
      conv_wait <= CONV_WAIT_RST;
      res_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      elapsed <= elapsed_next;
      bus_busy <= busy_next;
      byte_pos <= pos_next;
      result_count <= count_next;
      if (cfg_valid && cfg_index == CFG_START_WAIT) start_wait <= cfg_data[START_W-1:0];
      if (cfg_valid && cfg_index == CFG_CONV_WAIT) conv_wait <= cfg_data[CONV_W-1:0];
      if (load) begin
        res_valid <= 1'b1;
        res_kind <= o_kind;
        res_bus_addr <= o_addr;
        res_xfer_length <= o_len;
        res_write_first <= o_w1;
        res_write_second <= o_w2;
        res_temp_tenths <= o_temp;
        res_sample_index <= o_idx;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

### src/bst_dp.sv
`default_nettype none
module bst_dp import bst_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic [7:0] rx_byte,
  input  bst_cmd_t dcmd,
  output bst_stat_t stat
);

  localparam int DIFF_W = 17;
  localparam int PROD_W = 34;
  localparam int X1_W = 19;
  localparam int NUM_W = 27;
  localparam int B5_W = 28;
  localparam int T_W = 29;
  localparam int DIV_STEPS = NUM_W;
  localparam int CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {DP_IDLE, DP_MUL, DP_X1, DP_DIV, DP_FIN, DP_DONE} dp_state_t;

  dp_state_t state;
  logic [CAL_W-1:0] cal_ac5, cal_ac6, cal_mc, cal_md;
  logic [7:0] raw_high;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [X1_W-1:0] x1;
  logic [NUM_W-1:0] quo;
  logic [X1_W-1:0] dvs, rem;
  logic q_neg, div_zero;
  logic [CNT_W-1:0] cnt;
  logic signed [TEMP_W-1:0] temp;

  logic [7:0] ut_high;
  logic signed [PROD_W-1:0] prod_adj;
  logic signed [X1_W-1:0] x1_c, den_c;
  logic signed [NUM_W-1:0] num_c;
  logic [X1_W+1:0] sub;
  logic signed [B5_W-1:0] qs, b5;
  logic signed [T_W-1:0] t8, tq;

  assign ut_high = (dcmd.store_raw && dcmd.pos == '0) ? rx_byte : raw_high;

  // truncate toward zero on the scale by 2^15
  assign prod_adj = prod + (prod[PROD_W-1] ? PROD_W'(32767) : PROD_W'(0));
  assign x1_c = X1_W'(prod_adj >>> 15);
  assign den_c = x1_c + X1_W'($signed(cal_md));
  assign num_c = {cal_mc, 11'd0};

  assign sub = {1'b0, rem, quo[NUM_W-1]} - {2'b00, dvs};

  assign qs = q_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign b5 = B5_W'(x1) + qs;
  assign t8 = T_W'(b5) + T_W'(8);
  assign tq = (t8 + (t8[T_W-1] ? T_W'(15) : T_W'(0))) >>> 4;

  assign stat.done = (state == DP_DONE);
  assign stat.div_zero = div_zero;
  assign stat.temp = temp;
  assign stat.raw_high = raw_high;

  always_ff @(posedge clk) begin
    if (dcmd.store_raw && dcmd.pos == '0) raw_high <= rx_byte;
    if (dcmd.store_cal) begin
      if (dcmd.pos[4:1] == POS_AC5[4:1]) begin
        if (dcmd.pos[0]) cal_ac5[7:0] <= rx_byte; else cal_ac5[15:8] <= rx_byte;
      end
      if (dcmd.pos[4:1] == POS_AC6[4:1]) begin
        if (dcmd.pos[0]) cal_ac6[7:0] <= rx_byte; else cal_ac6[15:8] <= rx_byte;
      end
      if (dcmd.pos[4:1] == POS_MC[4:1]) begin
        if (dcmd.pos[0]) cal_mc[7:0] <= rx_byte; else cal_mc[15:8] <= rx_byte;
      end
      if (dcmd.pos[4:1] == POS_MD[4:1]) begin
        if (dcmd.pos[0]) cal_md[7:0] <= rx_byte; else cal_md[15:8] <= rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DP_IDLE;
    end else begin
      case (state)
        DP_MUL: begin
          prod <= diff * $signed({1'b0, cal_ac5});
          state <= DP_X1;
        end
        DP_X1: begin
          x1 <= x1_c;
          div_zero <= (den_c == '0);
          q_neg <= num_c[NUM_W-1] ^ den_c[X1_W-1];
          quo <= num_c[NUM_W-1] ? NUM_W'(-num_c) : NUM_W'(num_c);
          dvs <= den_c[X1_W-1] ? X1_W'(-den_c) : X1_W'(den_c);
          rem <= '0;
          cnt <= '0;
          state <= (den_c == '0) ? DP_DONE : DP_DIV;
        end
        DP_DIV: begin
          if (!sub[X1_W+1]) begin
            rem <= sub[X1_W-1:0];
            quo <= {quo[NUM_W-2:0], 1'b1};
          end else begin
            rem <= {rem[X1_W-2:0], quo[NUM_W-1]};
            quo <= {quo[NUM_W-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(DIV_STEPS - 1)) state <= DP_FIN;
        end
        DP_FIN: begin
          if (tq > T_W'(8388607)) temp <= 24'sh7fffff;
          else if (tq < -T_W'(8388608)) temp <= 24'sh800000;
          else temp <= tq[TEMP_W-1:0];
          state <= DP_DONE;
        end
        default: ;
      endcase
      if (dcmd.start) begin
        diff <= $signed({1'b0, ut_high, rx_byte}) - $signed({1'b0, cal_ac6});
        state <= DP_MUL;
      end
    end
  end

endmodule
`default_nettype wire

### src/bst_checker.sv
`default_nettype none
`include "baro_sensor_temp_sequencer_defines.svh"
module bst_checker import bst_pkg::*; (
  input logic clk,
  input logic rst,
  input logic evt_ready,
  input logic res_valid,
  input logic res_ready,
  input logic [KIND_W-1:0] res_kind,
  input logic [7:0] res_bus_addr,
  input logic [LEN_W-1:0] res_xfer_length
);

  `BST_ASSERT_NOW(a_kind_range, clk, rst, res_valid, res_kind <= KIND_DIV_ERR)
  `BST_ASSERT_NOW(a_write_addr, clk, rst, res_valid && res_kind == KIND_WRITE,
    res_bus_addr == ADDR_WRITE && (res_xfer_length == 5'd1 || res_xfer_length == 5'd2))
  `BST_ASSERT_NOW(a_read_len, clk, rst, res_valid && res_kind == KIND_READ,
    res_bus_addr == ADDR_READ && (res_xfer_length == 5'd1 || res_xfer_length == 5'd2 ||
    res_xfer_length == LEN_W'(CAL_BYTES)))
  `BST_ASSERT_NOW(a_no_take_on_stall, clk, rst, res_valid && !res_ready, !evt_ready)
  `BST_ASSERT_NEXT(a_hold, clk, rst, res_valid && !res_ready,
    res_valid && $stable(res_kind) && $stable(res_bus_addr))

endmodule

bind baro_sensor_temp_sequencer bst_checker u_bst_checker (
  .clk(clk),
  .rst(rst),
  .evt_ready(evt.ready),
  .res_valid(res.valid),
  .res_ready(res.ready),
  .res_kind(res.kind),
  .res_bus_addr(res.bus_addr),
  .res_xfer_length(res.xfer_length)
);
`default_nettype wire

### dv/baro_sensor_temp_sequencer_tb.sv
`default_nettype none
module baro_sensor_temp_sequencer_tb;
  import bst_pkg::*;

  // sequencer phases as the block walks through one reading
  typedef enum logic [3:0] {
    SQ_IDLE, SQ_ASK_ID, SQ_RCV_ID, SQ_ASK_CAL, SQ_RCV_CAL,
    SQ_ASK_TEMP, SQ_ASK_TEMP2, SQ_RCV_TEMP, SQ_HALT
  } seq_phase_t;

  // one result item as seen on the output channel
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [7:0] bus_addr;
    logic [LEN_W-1:0] xfer_length;
    logic [7:0] write_first;
    logic [7:0] write_second;
    logic signed [TEMP_W-1:0] temp_tenths;
    logic [7:0] sample_index;
  } bus_result_t;

  // predicts the bus requests and temperatures and holds them in order
  class temp_scoreboard;
    seq_phase_t phase;
    logic [START_W-1:0] elapsed;
    logic busy;
    logic [POS_W-1:0] pos;
    logic [CAL_W-1:0] ac5, ac6, mc, md;
    logic [7:0] raw_hi;
    logic [7:0] sample_count;
    logic [START_W-1:0] start_wait;
    logic [CONV_W-1:0] conv_wait;
    logic cal_done;
    int readings;
    int errors;
    bus_result_t expected[$];

    function void clear();
      phase = SQ_IDLE;
      elapsed = '0;
      busy = 1'b0;
      pos = '0;
      ac5 = '0; ac6 = '0; mc = '0; md = '0;
      raw_hi = '0;
      sample_count = '0;
      start_wait = START_WAIT_RST;
      conv_wait = CONV_WAIT_RST;
      cal_done = 1'b0;
      readings = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_START_WAIT) start_wait = data;
      else if (idx == CFG_CONV_WAIT) conv_wait = data[CONV_W-1:0];
    endfunction

    function void push(logic [KIND_W-1:0] k, logic [7:0] a, logic [LEN_W-1:0] n,
                       logic [7:0] w1, logic [7:0] w2, logic signed [TEMP_W-1:0] t,
                       logic [7:0] idx);
      bus_result_t r;
      r.kind = k; r.bus_addr = a; r.xfer_length = n;
      r.write_first = w1; r.write_second = w2;
      r.temp_tenths = t; r.sample_index = idx;
      expected.push_back(r);
    endfunction

    function void issue_write(logic [LEN_W-1:0] n, logic [7:0] w1, logic [7:0] w2,
                              seq_phase_t nxt);
      push(KIND_WRITE, ADDR_WRITE, n, w1, w2, '0, '0);
      busy = 1'b1;
      phase = nxt;
    endfunction

    function void issue_read(logic [LEN_W-1:0] n, seq_phase_t nxt);
      push(KIND_READ, ADDR_READ, n, '0, '0, '0, '0);
      busy = 1'b1;
      pos = '0;
      phase = nxt;
    endfunction

    function void compensate(logic [7:0] low);
      longint ut, x1, den, b5, t;
      ut = longint'({raw_hi, low});
      x1 = ((ut - longint'(ac6)) * longint'(ac5)) / 32768;
      den = x1 + longint'($signed(md));
      phase = SQ_IDLE;
      elapsed = '0;
      readings++;
      if (den == 0) begin
        push(KIND_DIV_ERR, '0, '0, '0, '0, '0, '0);
        return;
      end
      b5 = x1 + (longint'($signed(mc)) * 2048) / den;
      t = (b5 + 8) / 16;
      if (t > 8388607) t = 8388607;
      if (t < -8388608) t = -8388608;
      push(KIND_TEMP, '0, '0, '0, '0, t[TEMP_W-1:0], sample_count);
      sample_count++;
    endfunction

    function void store_byte(logic [7:0] b);
      if (phase == SQ_RCV_ID || phase == SQ_RCV_TEMP) begin
        if (pos == 0) raw_hi = b;
      end else if (pos < CAL_BYTES) begin
        case (pos)
          POS_AC5: ac5[15:8] = b;
          POS_AC5 + 1: ac5[7:0] = b;
          POS_AC6: ac6[15:8] = b;
          POS_AC6 + 1: ac6[7:0] = b;
          POS_MC: mc[15:8] = b;
          POS_MC + 1: mc[7:0] = b;
          POS_MD: md[15:8] = b;
          POS_MD + 1: begin
            md[7:0] = b;
            cal_done = 1'b1;
          end
          default: ;
        endcase
      end
      if (pos != 5'd31) pos++;
    endfunction

    function void note_event(logic [CMD_W-1:0] c, logic [7:0] b, logic l);
      logic wait_wr, wait_rd;
      wait_wr = phase inside {SQ_ASK_ID, SQ_ASK_CAL, SQ_ASK_TEMP, SQ_ASK_TEMP2};
      wait_rd = phase inside {SQ_RCV_ID, SQ_RCV_CAL, SQ_RCV_TEMP};
      if (c == CMD_NONE || phase == SQ_HALT) return;
      if (c == CMD_TICK) begin
        if (elapsed != '1) elapsed++;
      end else if (c == CMD_WDONE) begin
        if (wait_wr) busy = 1'b0;
      end else if (wait_rd && busy) begin
        store_byte(b);
        if (l) busy = 1'b0;
      end
      if (busy) return;
      case (phase)
        SQ_IDLE: if (elapsed > start_wait) issue_write(LEN_W'(1), REG_ID, '0, SQ_ASK_ID);
        SQ_ASK_ID: issue_read(LEN_W'(1), SQ_RCV_ID);
        SQ_RCV_ID: begin
          if (raw_hi != ID_VALUE) begin
            push(KIND_ID_ERR, '0, '0, '0, '0, '0, '0);
            phase = SQ_HALT;
          end else issue_write(LEN_W'(1), REG_CAL, '0, SQ_ASK_CAL);
        end
        SQ_ASK_CAL: issue_read(LEN_W'(CAL_BYTES), SQ_RCV_CAL);
        SQ_RCV_CAL: begin
          elapsed = '0;
          issue_write(LEN_W'(2), REG_CTRL, CONV_TEMP, SQ_ASK_TEMP);
        end
        SQ_ASK_TEMP:
          if (elapsed > conv_wait) issue_write(LEN_W'(1), REG_RESULT, '0, SQ_ASK_TEMP2);
        SQ_ASK_TEMP2: issue_read(LEN_W'(2), SQ_RCV_TEMP);
        SQ_RCV_TEMP: compensate(b);
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(bus_result_t got);
      bus_result_t exp;
      if (expected.size() == 0) begin
        report($sformatf("unexpected result of kind %0d", got.kind));
        return;
      end
      exp = expected.pop_front();
      if (got.kind !== exp.kind)
        report($sformatf("kind %0d, expected %0d", got.kind, exp.kind));
      if (got.bus_addr !== exp.bus_addr)
        report($sformatf("bus_addr %h, expected %h", got.bus_addr, exp.bus_addr));
      if (got.xfer_length !== exp.xfer_length)
        report($sformatf("xfer_length %0d, expected %0d", got.xfer_length, exp.xfer_length));
      if (got.write_first !== exp.write_first)
        report($sformatf("write_first %h, expected %h", got.write_first, exp.write_first));
      if (got.write_second !== exp.write_second)
        report($sformatf("write_second %h, expected %h", got.write_second, exp.write_second));
      if (got.temp_tenths !== exp.temp_tenths)
        report($sformatf("temp_tenths %0d, expected %0d", got.temp_tenths, exp.temp_tenths));
      if (got.sample_index !== exp.sample_index)
        report($sformatf("sample_index %0d, expected %0d", got.sample_index, exp.sample_index));
    endtask
  endclass

  logic clk;
  logic rst;
  bst_in_if evt ();
  bst_out_if res ();
  bst_cfg_if cfg ();

  baro_sensor_temp_sequencer uut (
    .clk(clk),
    .rst(rst),
    .evt(evt.sink),
    .res(res.source),
    .cfg(cfg.sink)
  );

  temp_scoreboard sb;

  // stimulus shaping, refreshed for each reading
  logic [7:0] cal_table [CAL_BYTES];
  logic [15:0] ut_word;
  int cal_len;
  int temp_len;
  logic bad_id;
  logic noisy;
  logic no_idle;
  logic no_idle_out;
  int accepted_items;
  logic stall_req;
  logic stall_on;
  int hold_left;

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // generous overall limit, far beyond the slowest correct run
  initial begin
    #16000000;
    $display("simulation failed");
    $finish;
  end

  // mostly short gaps, now and then a long one, none at all when asked
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side: random back-pressure, the odd long hold and one forced stall
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (res.valid && res.ready)
        sb.check_result('{kind: res.kind, bus_addr: res.bus_addr,
                          xfer_length: res.xfer_length, write_first: res.write_first,
                          write_second: res.write_second, temp_tenths: res.temp_tenths,
                          sample_index: res.sample_index});
      if (hold_left > 0) begin
        res.ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (stall_on) begin
        res.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < 2) begin
        res.ready <= 1'b0;
        hold_left <= $urandom_range(10, 40);
      end else begin
        res.ready <= no_idle_out ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
    end
  end

  // long receiver hold-off while the sender keeps offering items
  initial begin
    stall_on = 1'b0;
    wait (stall_req);
    repeat (30) @(posedge clk);
    stall_on = 1'b1;
    repeat (300) @(posedge clk);
    stall_on = 1'b0;
  end

  task send_event(logic [CMD_W-1:0] c, logic [7:0] b, logic l);
    int g;
    g = pick_gap();
    if (g > 0) begin
      evt.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    evt.valid <= 1'b1;
    evt.cmd <= c;
    evt.rx_byte <= b;
    evt.rx_last <= l;
    do @(posedge clk); while (!evt.ready);
    sb.note_event(c, b, l);
    accepted_items++;
  endtask

  // choose the event the sensor and bus master would produce next,
  // following the predicted phase; noise breaks sequences now and then
  task next_event(output logic [CMD_W-1:0] c, output logic [7:0] b, output logic l);
    int need;
    c = CMD_TICK;
    b = 8'($urandom_range(0, 255));
    l = 1'($urandom_range(0, 1));
    if (noisy && $urandom_range(0, 99) < 12) begin
      c = CMD_W'($urandom_range(0, 3));
      // a stray byte must not spoil the id or end an unfinished calibration
      if (c == CMD_BYTE && sb.phase == SQ_RCV_ID) c = CMD_TICK;
      if (sb.phase == SQ_RCV_CAL && !sb.cal_done) l = 1'b0;
      return;
    end
    case (sb.phase)
      SQ_ASK_ID, SQ_ASK_CAL, SQ_ASK_TEMP2: c = CMD_WDONE;
      SQ_ASK_TEMP: c = sb.busy ? CMD_WDONE : CMD_TICK;
      SQ_RCV_ID, SQ_RCV_CAL, SQ_RCV_TEMP: begin
        c = CMD_BYTE;
        if (sb.phase == SQ_RCV_ID) begin
          need = 1;
          b = bad_id ? (ID_VALUE ^ 8'($urandom_range(1, 255))) : ID_VALUE;
        end else if (sb.phase == SQ_RCV_CAL) begin
          need = sb.cal_done ? cal_len : ((cal_len < CAL_BYTES) ? CAL_BYTES : cal_len);
          if (sb.pos < CAL_BYTES) b = cal_table[sb.pos];
        end else begin
          need = temp_len;
          b = (sb.pos == 0) ? ut_word[15:8] : ut_word[7:0];
        end
        l = (int'(sb.pos) + 1 >= need);
      end
      default: c = CMD_TICK;
    endcase
  endtask

  // fresh random content for the next reading
  task random_reading();
    int r;
    foreach (cal_table[i]) cal_table[i] = 8'($urandom_range(0, 255));
    // a zero divisor now and then: no AC5 weight and MD zero
    if ($urandom_range(0, 99) < 12) begin
      cal_table[POS_AC5] = '0; cal_table[POS_AC5 + 1] = '0;
      cal_table[POS_MD] = '0; cal_table[POS_MD + 1] = '0;
    end
    ut_word = 16'($urandom_range(0, 65535));
    r = $urandom_range(0, 99);
    cal_len = (r < 80) ? CAL_BYTES : (r < 90) ? $urandom_range(23, 25) : $urandom_range(1, 21);
    r = $urandom_range(0, 99);
    temp_len = (r < 80) ? 2 : (r < 90) ? 1 : 3;
  endtask

  task run_reading(logic shuffle);
    int target;
    logic [CMD_W-1:0] c;
    logic [7:0] b;
    logic l;
    if (shuffle) random_reading();
    target = sb.readings + 1;
    while (sb.readings < target && sb.phase != SQ_HALT) begin
      next_event(c, b, l);
      send_event(c, b, l);
    end
  endtask

  // drain all expected results, then let the block settle
  task wait_quiet();
    int n;
    n = 0;
    evt.valid <= 1'b0;
    while (sb.expected.size() != 0 && n < 200000) begin
      @(posedge clk);
      n++;
    end
    repeat (60) @(posedge clk);
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= data;
    do @(posedge clk); while (!cfg.ready);
    sb.set_reg(idx, data);
    cfg.valid <= 1'b0;
  endtask

  task set_table(logic [15:0] a5, logic [15:0] a6, logic [15:0] m_c, logic [15:0] m_d,
                 logic [15:0] ut);
    foreach (cal_table[i]) cal_table[i] = 8'($urandom_range(0, 255));
    {cal_table[POS_AC5], cal_table[POS_AC5 + 1]} = a5;
    {cal_table[POS_AC6], cal_table[POS_AC6 + 1]} = a6;
    {cal_table[POS_MC], cal_table[POS_MC + 1]} = m_c;
    {cal_table[POS_MD], cal_table[POS_MD + 1]} = m_d;
    ut_word = ut;
  endtask

  function logic [CMD_W-1:0] CMD_CODE_RAND();
    return CMD_W'($urandom_range(0, 3));
  endfunction

  initial begin
    int n;
    sb = new();
    sb.clear();
    rst = 1'b1;
    evt.valid <= 1'b0;
    evt.cmd <= CMD_TICK;
    evt.rx_byte <= '0;
    evt.rx_last <= 1'b0;
    cfg.valid <= 1'b0;
    cfg.index <= CFG_START_WAIT;
    cfg.data <= '0;
    accepted_items = 0;
    stall_req = 1'b0;
    bad_id = 1'b0;
    noisy = 1'b0;
    no_idle = 1'b0;
    no_idle_out = 1'b0;
    cal_len = CAL_BYTES;
    temp_len = 2;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_reg(CFG_START_WAIT, 24'd6);

    // stray events in idle and the unused command are all ignored
    send_event(CMD_WDONE, 8'hff, 1'b1);
    send_event(CMD_BYTE, 8'h00, 1'b1);
    send_event(CMD_NONE, 8'ha5, 1'b0);

    // first reading with a short start wait and the reset conversion wait,
    // calibration at its extremes
    set_table(16'hffff, 16'h0000, 16'h8000, 16'h7fff, 16'hffff);
    run_reading(1'b0);
    wait_quiet();
    write_reg(CFG_START_WAIT, '0);
    write_reg(CFG_CONV_WAIT, '0);

    // zero divisor, then the opposite extremes with a long calibration
    // read and a temperature read that ends on its first byte
    set_table(16'h0000, 16'h1234, 16'h4321, 16'h0000, 16'h0000);
    run_reading(1'b0);
    set_table(16'h8000, 16'hffff, 16'h7fff, 16'h8000, 16'h0000);
    cal_len = 24;
    temp_len = 1;
    run_reading(1'b0);
    cal_len = CAL_BYTES;
    temp_len = 2;

    // a long conversion wait, ticks sent back to back
    wait_quiet();
    write_reg(CFG_CONV_WAIT, 24'd50);
    no_idle = 1'b1;
    set_table(16'h7fff, 16'h8000, 16'hffff, 16'h0001, 16'h8000);
    run_reading(1'b0);
    no_idle = 1'b0;

    // longest start wait: ticks pile up but nothing starts
    wait_quiet();
    write_reg(CFG_START_WAIT, 24'hffffff);
    write_reg(CFG_CONV_WAIT, 24'd3);
    for (n = 0; n < 40; n++) send_event(CMD_TICK, 8'($urandom_range(0, 255)), 1'b0);
    wait_quiet();
    write_reg(CFG_START_WAIT, 24'd4);

    // random part: noisy readings, thresholds changed between some of them
    noisy = 1'b1;
    stall_req = 1'b1;
    n = accepted_items;
    while (accepted_items - n < 450) begin
      no_idle = ($urandom_range(0, 5) == 0);
      no_idle_out = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 3) == 0) begin
        wait_quiet();
        if (sb.phase == SQ_IDLE) begin
          write_reg(CFG_START_WAIT, CFG_DATA_W'($urandom_range(0, 12)));
          write_reg(CFG_CONV_WAIT, CFG_DATA_W'($urandom_range(0, 12)));
        end
      end
      run_reading(1'b1);
    end

    // a wrong id halts the block; everything after it is ignored
    noisy = 1'b0;
    no_idle = 1'b0;
    bad_id = 1'b1;
    random_reading();
    while (sb.phase != SQ_HALT) run_reading(1'b0);
    for (n = 0; n < 12; n++)
      send_event(CMD_CODE_RAND(), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    wait_quiet();

    if (sb.expected.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected.size()));
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

### filelist.f
+incdir+src
src/bst_pkg.sv
src/bst_in_if.sv
src/bst_out_if.sv
src/bst_cfg_if.sv
src/bst_ctrl.sv
src/bst_dp.sv
src/baro_sensor_temp_sequencer.sv
src/bst_checker.sv
dv/baro_sensor_temp_sequencer_tb.sv
